### hw/rtl/i2ctrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2ctrb_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   localparam logic [6:0] OWN_ADDRESS_RESET = 7'h0A;
   localparam logic [7:0] BUFFER_RESET_BYTE = 8'h01;

   // register index, taken from paddr[2]
   localparam logic CSR_OWN_ADDRESS = 1'b0;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ADDR     = 4'd1,
      PH_RW       = 4'd2,
      PH_ADDR_ACK = 4'd3,
      PH_ACK_HOLD = 4'd4,
      PH_WDATA    = 4'd5,
      PH_WACK     = 4'd6,
      PH_RDATA    = 4'd7,
      PH_RACK     = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_READ  = 2'd1,
      DIR_WRITE = 2'd2
   } dir_type;

   // one classified bus sample
   typedef struct packed {
      logic start;
      logic stop;
      logic rise;
      logic fall;
      logic sda;
   } ev_type;

   typedef struct packed {
      logic       sda_pull_low;
      logic       selected;
      logic       reading;
      logic [3:0] buffer_pointer;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/i2ctrb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH))
      else $error("queue count above depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_wr_rd_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers apart while empty");
`endif

endmodule

`default_nettype wire

### hw/rtl/i2ctrb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                full,
   input  logic                scl_level,
   input  logic                sda_level,
   output logic                ev_push,
   output i2ctrb_pkg::ev_type  ev
);

   import i2ctrb_pkg::*;

   logic last_scl_ff, last_scl_in;
   logic last_sda_ff, last_sda_in;
   logic high_both;

   assign ev_push   = push && !full;
   assign high_both = scl_level && last_scl_ff;

   // start and stop only count while SCL stays high over both samples
   always_comb begin
      ev.start = high_both && last_sda_ff && !sda_level;
      ev.stop  = high_both && !last_sda_ff && sda_level;
      ev.rise  = scl_level && !last_scl_ff;
      ev.fall  = !scl_level && last_scl_ff;
      ev.sda   = sda_level;
   end

   always_comb begin
      last_scl_in = last_scl_ff;
      last_sda_in = last_sda_ff;
      if (ev_push) begin
         last_scl_in = scl_level;
         last_sda_in = sda_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scl_ff <= 1'b1;
         last_sda_ff <= 1'b1;
      end else begin
         last_scl_ff <= last_scl_in;
         last_sda_ff <= last_sda_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/i2ctrb_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module i2ctrb_engine #(
   parameter int BUFFER_DEPTH = i2ctrb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           own_address,
   input  logic                 ev_valid,
   input  i2ctrb_pkg::ev_type   ev,
   output logic                 ev_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output i2ctrb_pkg::rsp_type  rsp
);

   import i2ctrb_pkg::*;

   localparam int PW = $clog2(BUFFER_DEPTH);

   phase_type     phase_ff, phase_in;
   dir_type       dir_ff, dir_in;
   logic [7:0]    shift_ff, shift_in;
   logic [2:0]    bit_count_ff, bit_count_in;
   logic [PW-1:0] ptr_ff, ptr_in, ptr_adv;
   logic          drive_ff, drive_in;

   logic [7:0]    mem [BUFFER_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          rd_valid_ff;
   logic [BUFFER_DEPTH-1:0] valid_ff;
   logic          wr_en;
   logic          fire;
   logic [6:0]    addr_shift;
   logic [7:0]    rd_byte;
   logic [PW+3:0] ptr_wide;

   assign fire       = ev_valid && !rsp_full;
   assign ev_pop     = fire;
   assign rsp_push   = fire;
   assign addr_shift = {shift_ff[5:0], ev.sda};
   assign ptr_adv    = (ptr_ff == PW'(BUFFER_DEPTH-1)) ? '0 : ptr_ff + 1'b1;
   // never-written entries read back as the reset byte
   assign rd_byte    = rd_valid_ff ? rd_data_ff : BUFFER_RESET_BYTE;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         priority if (ev.start) begin
            phase_in = PH_ADDR;
         end else if (ev.stop) begin
            phase_in = PH_IDLE;
         end else begin
            unique case (phase_ff)
               PH_IDLE: phase_in = PH_IDLE;
               PH_ADDR: begin
                  if (ev.rise && bit_count_ff == 3'd6) begin
                     phase_in = (addr_shift == own_address) ? PH_RW : PH_IDLE;
                  end
               end
               PH_RW: if (ev.rise) phase_in = PH_ADDR_ACK;
               PH_ADDR_ACK: if (ev.fall) phase_in = PH_ACK_HOLD;
               PH_ACK_HOLD: begin
                  if (ev.fall) begin
                     phase_in = (dir_ff == DIR_READ) ? PH_RDATA : PH_WDATA;
                  end
               end
               PH_WDATA: if (ev.rise && bit_count_ff == 3'd7) phase_in = PH_WACK;
               PH_WACK: if (ev.fall) phase_in = PH_ACK_HOLD;
               PH_RDATA: if (ev.fall && bit_count_ff == 3'd0) phase_in = PH_RACK;
               PH_RACK: begin
                  if (ev.rise) begin
                     phase_in = ev.sda ? PH_IDLE : PH_ACK_HOLD;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // datapath updates per phase
   always_comb begin
      dir_in       = dir_ff;
      shift_in     = shift_ff;
      bit_count_in = bit_count_ff;
      ptr_in       = ptr_ff;
      drive_in     = drive_ff;
      wr_en        = 1'b0;
      if (fire) begin
         priority if (ev.start) begin
            shift_in     = '0;
            bit_count_in = '0;
            dir_in       = DIR_NONE;
            drive_in     = 1'b0;
         end else if (ev.stop) begin
            shift_in     = '0;
            bit_count_in = '0;
            dir_in       = DIR_NONE;
            ptr_in       = '0;
            drive_in     = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_ADDR: begin
                  if (ev.rise) begin
                     shift_in     = {1'b0, addr_shift};
                     bit_count_in = bit_count_ff + 1'b1;
                     // seventh address bit: compare and restart the count
                     if (bit_count_ff == 3'd6) begin
                        bit_count_in = '0;
                        if (addr_shift != own_address) begin
                           dir_in   = DIR_NONE;
                           ptr_in   = '0;
                           shift_in = '0;
                        end
                     end
                  end
               end
               PH_RW: begin
                  if (ev.rise) begin
                     dir_in = ev.sda ? DIR_READ : DIR_WRITE;
                  end
               end
               PH_ADDR_ACK: begin
                  if (ev.fall) begin
                     drive_in = 1'b1;
                     if (dir_ff == DIR_READ) begin
                        shift_in = rd_byte;
                        ptr_in   = ptr_adv;
                     end
                  end
               end
               PH_ACK_HOLD: begin
                  if (ev.fall) begin
                     if (dir_ff == DIR_READ) begin
                        drive_in     = !shift_ff[7];
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_count_in = 3'd1;
                     end else begin
                        drive_in     = 1'b0;
                        shift_in     = '0;
                        bit_count_in = '0;
                     end
                  end
               end
               PH_WDATA: begin
                  if (ev.rise) begin
                     shift_in     = {shift_ff[6:0], ev.sda};
                     bit_count_in = bit_count_ff + 1'b1;
                  end
               end
               PH_WACK: begin
                  if (ev.fall) begin
                     wr_en    = 1'b1;
                     ptr_in   = ptr_adv;
                     drive_in = 1'b1;
                  end
               end
               PH_RDATA: begin
                  if (ev.fall) begin
                     if (bit_count_ff != 3'd0) begin
                        drive_in     = !shift_ff[7];
                        shift_in     = {shift_ff[6:0], 1'b0};
                        bit_count_in = bit_count_ff + 1'b1;
                     end else begin
                        drive_in = 1'b0;
                     end
                  end
               end
               PH_RACK: begin
                  if (ev.rise && !ev.sda) begin
                     shift_in = rd_byte;
                     ptr_in   = ptr_adv;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      ptr_wide           = {4'b0, ptr_in};
      rsp.sda_pull_low   = drive_in;
      rsp.selected       = (dir_in != DIR_NONE);
      rsp.reading        = (dir_in == DIR_READ);
      rsp.buffer_pointer = ptr_wide[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         dir_ff       <= DIR_NONE;
         shift_ff     <= '0;
         bit_count_ff <= '0;
         ptr_ff       <= '0;
         drive_ff     <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
         shift_ff     <= shift_in;
         bit_count_ff <= bit_count_in;
         ptr_ff       <= ptr_in;
         drive_ff     <= drive_in;
         if (wr_en) begin
            valid_ff[ptr_ff] <= 1'b1;
         end
         // prefetch the entry the pointer will hold; a write never hits it
         rd_valid_ff  <= valid_ff[ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= shift_ff;
      end
      rd_data_ff <= mem[ptr_in];
   end

`ifndef SYNTHESIS
   a_stop_releases: assert property (@(posedge clock) disable iff (reset)
      (fire && ev.stop) |=> (!drive_ff && phase_ff == PH_IDLE && ptr_ff == '0))
      else $error("stop did not release the bus");

   a_wdata_is_write: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WDATA || phase_ff == PH_WACK) |-> (dir_ff == DIR_WRITE))
      else $error("write phase without write direction");

   a_rdata_is_read: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RDATA || phase_ff == PH_RACK) |-> (dir_ff == DIR_READ))
      else $error("read phase without read direction");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(phase_ff) && $stable(ptr_ff) && $stable(drive_ff)))
      else $error("state moved without a transaction");
`endif

endmodule

`default_nettype wire

### hw/rtl/i2c_target_register_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                      Moves
// -------   ----------------------------------------   ----------------------------
// request   push, full, req_scl_level, req_sda_level   one SCL/SDA sample
// response  pop, empty, rsp_*                          SDA drive, status, pointer
// csr       psel, penable, pwrite, paddr, pwdata, ...  own_address at byte addr 0
//
// One sample per cycle sustained while pop keeps up; a sample's response reaches
// the rsp ports through the event queue, the engine and the response queue.
// The engine reads the byte buffer ahead of use through a registered prefetch.
// Reset is synchronous; the buffer needs no clearing pass, per-entry valid bits
// make unwritten bytes read as 0x01. full rises once both two-entry queues fill.

module i2c_target_register_buffer #(
   parameter int BUFFER_DEPTH = i2ctrb_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH  = i2ctrb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_scl_level,
   input  logic        req_sda_level,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_sda_pull_low,
   output logic        rsp_selected,
   output logic        rsp_reading,
   output logic [3:0]  rsp_buffer_pointer,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   import i2ctrb_pkg::*;

   logic [6:0] own_addr_ff, own_addr_in;
   logic       csr_write;

   ev_type     ev_front, ev_back;
   logic       ev_push, ev_empty, ev_pop;
   rsp_type    rsp_engine, rsp_head;
   logic       rsp_push, rsp_full;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == CSR_OWN_ADDRESS);
   assign prdata    = (paddr[2] == CSR_OWN_ADDRESS) ? {25'b0, own_addr_ff} : '0;
   assign own_addr_in = csr_write ? pwdata[6:0] : own_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= OWN_ADDRESS_RESET;
      end else begin
         own_addr_ff <= own_addr_in;
      end
   end

   i2ctrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .scl_level (req_scl_level),
      .sda_level (req_sda_level),
      .ev_push   (ev_push),
      .ev        (ev_front)
   );

   i2ctrb_queue #(
      .WIDTH ($bits(ev_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_ev_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_front),
      .full      (full),
      .pop       (ev_pop),
      .pop_data  (ev_back),
      .empty     (ev_empty)
   );

   i2ctrb_engine #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_addr_ff),
      .ev_valid    (!ev_empty),
      .ev          (ev_back),
      .ev_pop      (ev_pop),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (rsp_engine)
   );

   i2ctrb_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_engine),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_head),
      .empty     (empty)
   );

   assign rsp_sda_pull_low   = rsp_head.sda_pull_low;
   assign rsp_selected       = rsp_head.selected;
   assign rsp_reading        = rsp_head.reading;
   assign rsp_buffer_pointer = rsp_head.buffer_pointer;

endmodule

`default_nettype wire

### tb/tb_i2c_target_register_buffer.sv
`timescale 1ns / 1ps

module tb_i2c_target_register_buffer;
   import i2ctrb_pkg::*;

   localparam int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 300;
   localparam int LONG_HOLD    = 64;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_scl_level = 1'b1;
   logic        req_sda_level = 1'b1;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_sda_pull_low;
   logic        rsp_selected;
   logic        rsp_reading;
   logic [3:0]  rsp_buffer_pointer;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   i2c_target_register_buffer u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_scl_level      (req_scl_level),
      .req_sda_level      (req_sda_level),
      .empty              (empty),
      .pop                (pop),
      .rsp_sda_pull_low   (rsp_sda_pull_low),
      .rsp_selected       (rsp_selected),
      .rsp_reading        (rsp_reading),
      .rsp_buffer_pointer (rsp_buffer_pointer),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // target state as the bus samples drive it
   logic [6:0] own_addr_model;
   logic [7:0] model_buffer [BUFFER_DEPTH];
   logic [7:0] model_shift;
   phase_type  model_phase;
   logic [2:0] model_bits;
   dir_type    model_dir;
   int         model_ptr;
   logic       model_last_scl;
   logic       model_last_sda;
   logic       model_pull;

   rsp_type    line_state_q [$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         sample_count = 0;

   // stimulus side
   logic       bus_scl = 1'b1;
   logic       bus_sda = 1'b1;
   logic [6:0] own_setting = OWN_ADDRESS_RESET;
   bit         tx_idle_en = 1'b1;
   bit         rx_idle_en = 1'b1;
   bit         long_hold_req = 1'b0;
   int         hold_left = 0;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void advance_model_ptr();
      model_ptr = (model_ptr + 1) % BUFFER_DEPTH;
   endfunction

   function automatic void shift_out_bit();
      model_pull  = ~model_shift[7];
      model_shift = {model_shift[6:0], 1'b0};
   endfunction

   function automatic rsp_type predict_line_state(input logic scl, input logic sda);
      logic    high_both;
      logic    rise;
      logic    fall;
      rsp_type r;
      high_both = scl && model_last_scl;
      rise      = scl && !model_last_scl;
      fall      = !scl && model_last_scl;
      if (high_both && model_last_sda && !sda) begin
         model_phase = PH_ADDR;
         model_shift = '0;
         model_bits  = '0;
         model_dir   = DIR_NONE;
         model_pull  = 1'b0;
      end else if (high_both && !model_last_sda && sda) begin
         model_phase = PH_IDLE;
         model_shift = '0;
         model_bits  = '0;
         model_dir   = DIR_NONE;
         model_ptr   = 0;
         model_pull  = 1'b0;
      end else begin
         case (model_phase)
            PH_ADDR: begin
               if (rise) begin
                  model_shift = {1'b0, model_shift[5:0], sda};
                  model_bits  = model_bits + 3'd1;
                  if (model_bits == 3'd7) begin
                     model_bits = '0;
                     if (model_shift[6:0] == own_addr_model) begin
                        model_phase = PH_RW;
                     end else begin
                        model_phase = PH_IDLE;
                        model_dir   = DIR_NONE;
                        model_ptr   = 0;
                        model_shift = '0;
                     end
                  end
               end
            end
            PH_RW: begin
               if (rise) begin
                  model_dir   = sda ? DIR_READ : DIR_WRITE;
                  model_phase = PH_ADDR_ACK;
               end
            end
            PH_ADDR_ACK: begin
               if (fall) begin
                  model_pull = 1'b1;
                  if (model_dir == DIR_READ) begin
                     model_shift = model_buffer[model_ptr];
                     advance_model_ptr();
                  end
                  model_phase = PH_ACK_HOLD;
               end
            end
            PH_ACK_HOLD: begin
               if (fall) begin
                  if (model_dir == DIR_READ) begin
                     shift_out_bit();
                     model_bits  = 3'd1;
                     model_phase = PH_RDATA;
                  end else begin
                     model_pull  = 1'b0;
                     model_shift = '0;
                     model_bits  = '0;
                     model_phase = PH_WDATA;
                  end
               end
            end
            PH_WDATA: begin
               if (rise) begin
                  model_shift = {model_shift[6:0], sda};
                  model_bits  = model_bits + 3'd1;
                  if (model_bits == 3'd0) model_phase = PH_WACK;
               end
            end
            PH_WACK: begin
               if (fall) begin
                  model_buffer[model_ptr] = model_shift;
                  advance_model_ptr();
                  model_pull  = 1'b1;
                  model_phase = PH_ACK_HOLD;
               end
            end
            PH_RDATA: begin
               if (fall) begin
                  if (model_bits != 3'd0) begin
                     shift_out_bit();
                     model_bits = model_bits + 3'd1;
                  end else begin
                     model_pull  = 1'b0;
                     model_phase = PH_RACK;
                  end
               end
            end
            PH_RACK: begin
               if (rise) begin
                  if (sda) begin
                     model_phase = PH_IDLE;
                  end else begin
                     model_shift = model_buffer[model_ptr];
                     advance_model_ptr();
                     model_phase = PH_ACK_HOLD;
                  end
               end
            end
            default: model_phase = PH_IDLE;
         endcase
      end
      model_last_scl = scl;
      model_last_sda = sda;
      r.sda_pull_low   = model_pull;
      r.selected       = (model_dir != DIR_NONE);
      r.reading        = (model_dir == DIR_READ);
      r.buffer_pointer = model_ptr[3:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  line_state_q.size());
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset) begin
         if (psel && penable && pwrite && pready && paddr[2] == CSR_OWN_ADDRESS)
            own_addr_model = pwdata[6:0];
         if (pop && !empty) begin
            got = '{sda_pull_low: rsp_sda_pull_low, selected: rsp_selected,
                    reading: rsp_reading, buffer_pointer: rsp_buffer_pointer};
            if (line_state_q.size() == 0) begin
               report_mismatch($sformatf("result %p with nothing pending", got));
            end else begin
               want = line_state_q.pop_front();
               if (got.sda_pull_low !== want.sda_pull_low)
                  report_mismatch($sformatf("sda_pull_low %b, expected %b",
                                            got.sda_pull_low, want.sda_pull_low));
               if (got.selected !== want.selected)
                  report_mismatch($sformatf("selected %b, expected %b",
                                            got.selected, want.selected));
               if (got.reading !== want.reading)
                  report_mismatch($sformatf("reading %b, expected %b",
                                            got.reading, want.reading));
               if (got.buffer_pointer !== want.buffer_pointer)
                  report_mismatch($sformatf("buffer_pointer %0d, expected %0d",
                                            got.buffer_pointer, want.buffer_pointer));
            end
         end
         if (push && !full)
            line_state_q.push_back(predict_line_state(req_scl_level, req_sda_level));
      end
   end

   // result side: random pop bursts, plus one long hold on request
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         pop <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LONG_HOLD - 1;
         pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(0, 7);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   task automatic send_sample(input logic scl, input logic sda);
      int gap;
      gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_scl_level <= scl;
      req_sda_level <= sda;
      bus_scl = scl;
      bus_sda = sda;
      sample_count++;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // one SCL period: set data while low, hold it through the high part
   task automatic clock_bit(input logic b);
      int high_len;
      high_len = $urandom_range(1, 2);
      if (bus_scl) send_sample(1'b0, bus_sda);
      if (bus_sda != b) send_sample(1'b0, b);
      repeat (high_len) send_sample(1'b1, b);
      send_sample(1'b0, b);
   endtask

   task automatic start_condition();
      if (!bus_sda) begin
         if (bus_scl) send_sample(1'b0, 1'b0);
         send_sample(1'b0, 1'b1);
      end
      if (!bus_scl) send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
   endtask

   task automatic stop_condition();
      if (bus_sda) begin
         if (bus_scl) send_sample(1'b0, 1'b1);
         send_sample(1'b0, 1'b0);
      end
      if (!bus_scl) send_sample(1'b1, 1'b0);
      send_sample(1'b1, 1'b1);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic ack);
      for (int i = 7; i >= 0; i--) clock_bit(b[i]);
      clock_bit(ack);
   endtask

   task automatic write_transfer(input logic [6:0] addr, input int nbytes, input bit with_stop);
      start_condition();
      send_byte({addr, 1'b0}, 1'b0);
      repeat (nbytes) send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
      if (with_stop) stop_condition();
   endtask

   // controller acks every byte but the last, which it NACKs
   task automatic read_transfer(input logic [6:0] addr, input int nbytes, input bit with_stop);
      start_condition();
      send_byte({addr, 1'b1}, 1'b0);
      for (int i = 0; i < nbytes; i++) send_byte(8'($urandom), i == nbytes - 1);
      if (with_stop) stop_condition();
   endtask

   task automatic write_own_address(input logic [6:0] value);
      @(negedge clock);
      push <= 1'b0;
      while (line_state_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_OWN_ADDRESS, 2'b00};
      pwdata  <= {25'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[6:0] !== value)
         report_mismatch($sformatf("own_address reads %0d, wrote %0d", prdata[6:0], value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      own_setting = value;
   endtask

   task automatic test_write_then_read();
      start_condition();
      send_byte({own_setting, 1'b0}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hA5, 1'b0);
      stop_condition();
      // last byte comes from an unwritten entry
      read_transfer(own_setting, 4, 1'b1);
   endtask

   task automatic test_address_mismatch();
      write_transfer(own_setting ^ 7'h01, 1, 1'b1);
      read_transfer(own_setting ^ 7'h40, 1, 1'b1);
   endtask

   task automatic test_repeated_start();
      write_transfer(own_setting, 1, 1'b0);
      read_transfer(own_setting, 1, 1'b0);
      write_transfer(own_setting, 1, 1'b1);
   endtask

   task automatic test_sda_edges_not_conditions();
      logic [7:0] addr_byte;
      addr_byte = {own_setting, 1'b0};
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b1);
      send_sample(1'b0, 1'b0);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b1);
      start_condition();
      // SDA changes in the very sample where SCL rises
      for (int i = 7; i >= 0; i--) begin
         send_sample(1'b0, ~addr_byte[i]);
         send_sample(1'b1, addr_byte[i]);
         send_sample(1'b0, addr_byte[i]);
      end
      clock_bit(1'b0);
      send_byte(8'h5A, 1'b0);
      stop_condition();
   endtask

   task automatic test_nack_keeps_direction();
      read_transfer(own_setting, 1, 1'b0);
      repeat (3) clock_bit(1'($urandom));
      start_condition();
      stop_condition();
   endtask

   // the wrapped write lands on entry zero, which the read then returns
   task automatic test_pointer_wrap();
      write_transfer(own_setting, BUFFER_DEPTH + 1, 1'b1);
      read_transfer(own_setting, 2, 1'b1);
   endtask

   task automatic test_address_extremes();
      write_own_address(7'd0);
      write_transfer(7'd0, 1, 1'b1);
      read_transfer(7'd0, 1, 1'b1);
      write_own_address(7'd127);
      write_transfer(7'd127, 1, 1'b1);
      read_transfer(7'd127, 1, 1'b1);
      write_transfer(7'd0, 1, 1'b1);
      write_own_address(OWN_ADDRESS_RESET);
   endtask

   task automatic test_backpressure();
      tx_idle_en = 1'b0;
      long_hold_req = 1'b1;
      write_transfer(own_setting, 3, 1'b1);
      tx_idle_en = 1'b1;
   endtask

   task automatic test_random_traffic();
      int         stop_at;
      int         phase_end;
      int         kind;
      int         n;
      logic [6:0] addr;
      stop_at = sample_count + RANDOM_ITEMS;
      while (sample_count < stop_at) begin
         case ($urandom_range(0, 3))
            0: write_own_address(7'd0);
            1: write_own_address(7'd127);
            2: write_own_address(OWN_ADDRESS_RESET);
            default: write_own_address(7'($urandom));
         endcase
         if (stop_at - sample_count < 400) begin
            tx_idle_en = 1'b0;
            rx_idle_en = 1'b0;
         end else begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
         end
         phase_end = sample_count + 350;
         while (sample_count < phase_end && sample_count < stop_at) begin
            kind = $urandom_range(0, 19);
            addr = ($urandom_range(0, 4) == 0) ? 7'($urandom) : own_setting;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 3);
            if (kind < 7) begin
               write_transfer(addr, n, $urandom_range(0, 3) != 0);
            end else if (kind < 14) begin
               read_transfer(addr, n + 1, $urandom_range(0, 3) != 0);
            end else if (kind < 17) begin
               // abort somewhere inside a transfer
               start_condition();
               repeat ($urandom_range(0, 12)) clock_bit(1'($urandom));
               if ($urandom_range(0, 1)) stop_condition();
            end else begin
               repeat ($urandom_range(1, 12)) send_sample(1'($urandom), 1'($urandom));
            end
         end
      end
   endtask

   initial begin
      model_phase    = PH_IDLE;
      model_shift    = '0;
      model_bits     = '0;
      model_dir      = DIR_NONE;
      model_ptr      = 0;
      model_last_scl = 1'b1;
      model_last_sda = 1'b1;
      model_pull     = 1'b0;
      own_addr_model = OWN_ADDRESS_RESET;
      for (int i = 0; i < BUFFER_DEPTH; i++) model_buffer[i] = BUFFER_RESET_BYTE;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_write_then_read();
      test_address_mismatch();
      test_repeated_start();
      test_sda_edges_not_conditions();
      test_nack_keeps_direction();
      test_pointer_wrap();
      test_address_extremes();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      push <= 1'b0;
      while (line_state_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/i2ctrb_pkg.sv
hw/rtl/i2ctrb_queue.sv
hw/rtl/i2ctrb_front.sv
hw/rtl/i2ctrb_engine.sv
hw/rtl/i2c_target_register_buffer.sv
tb/tb_i2c_target_register_buffer.sv
